@@ rtl/rmslm_pkg.sv @@
// rms level meter package: widths, register indexes, reset values and
// the controller/datapath command and status types; no dependencies
package rmslm_pkg;

    localparam int IN_W        = 12;
    localparam int SAMPLE_BITS = 12;
    localparam int MEAS_W      = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
    localparam int SQ_W        = 2 * MEAS_W;
    localparam int SUM_W       = 32;
    localparam int CNT_W       = 8;
    localparam int REF_W       = 13;
    localparam int OUT_W       = 17;
    localparam int MEAN_SHIFT  = 8;
    localparam int RAD_W       = SUM_W + MEAN_SHIFT;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int REM_W       = ROOT_W + 2;
    localparam int PROD_W      = ROOT_W + REF_W;
    localparam int STEP_W      = $clog2(SUM_W + 1);
    localparam int DIV_STEPS   = SUM_W;
    localparam int SQRT_STEPS  = ROOT_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_MV   = 2'd2;

    localparam logic             RST_CHANNEL_SELECT = 1'b1;
    localparam logic [CNT_W-1:0] RST_WINDOW_LENGTH  = 8'd100;
    localparam logic [REF_W-1:0] RST_REFERENCE_MV   = 13'd3300;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef struct packed {
        logic accept;
        logic acc;
        logic div_step;
        logic sqrt_load;
        logic sqrt_step;
        logic mul;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic win_end;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/block_rms_level_meter.sv @@
// windowed rms level meter top level: controller plus datapath
// an item that does not close the window is accumulated, then the block
// returns to idle; the closing item is followed by 32 divide steps and 20
// square root steps, a scaling step and the result load, which waits while
// the previous result is held; no new item is taken until back in idle
// reset: synchronous active low, clears sum, count and result valid, loads
// register defaults
module block_rms_level_meter import rmslm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [IN_W-1:0]       i_sample_first,
    input  logic [IN_W-1:0]       i_sample_second,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [OUT_W-1:0]      o_rms_sixteenth_mv
);

    t_cmd cmd;
    t_sts sts;

    rmslm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rmslm_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_sample_first     (i_sample_first),
        .i_sample_second    (i_sample_second),
        .i_out_stall        (i_out_stall),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_out_valid        (o_out_valid),
        .o_rms_sixteenth_mv (o_rms_sixteenth_mv)
    );

`ifndef ASSERT_OFF
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block took a second item right after one");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over a held result");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.div_step && cmd.sqrt_step))
        else $error("divider and square root stepped together");

    a_load_then_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out_valid)
        else $error("result register not valid after load");
`endif

endmodule

@@ rtl/rmslm_ctrl.sv @@
// rms level meter controller: one-hot sequencer for accumulate, divide,
// square root and scaling steps; depends on rmslm_pkg
module rmslm_ctrl import rmslm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ACC  = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_SQL  = 7'b0001000,
        S_SQRT = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.win_end) begin
                    n_state = S_DIV;
                    n_step  = STEP_W'(DIV_STEPS - 1);
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_SQL;
                end
            end
            S_SQL: begin
                o_cmd.sqrt_load = 1'b1;
                n_state         = S_SQRT;
                n_step          = STEP_W'(SQRT_STEPS - 1);
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step          = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

@@ rtl/rmslm_dp.sv @@
// rms level meter datapath: config registers, square and accumulate,
// bit-serial divider, digit-serial square root, scaling and result register
// depends on rmslm_pkg
module rmslm_dp import rmslm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [IN_W-1:0]       i_sample_first,
    input  logic [IN_W-1:0]       i_sample_second,
    input  logic                  i_out_stall,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output logic [OUT_W-1:0]      o_rms_sixteenth_mv
);

    logic             r_chan;
    logic [CNT_W-1:0] r_win;
    logic [REF_W-1:0] r_ref;

    logic [SQ_W-1:0]   r_sq;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_taken;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_srem;
    logic [ROOT_W-1:0] r_root;
    logic [PROD_W-1:0] r_prod;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic [IN_W-1:0]   sel_sample;
    logic [MEAS_W-1:0] meas;
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-1:0]  sum_sat;
    logic [CNT_W:0]    cnt_next;
    logic [CNT_W:0]    win_ext;
    logic              win_end;
    logic [CNT_W:0]    div_trial;
    logic [CNT_W:0]    div_diff;
    logic              div_ge;
    logic [REM_W+1:0]  sq_trial;
    logic [REM_W+1:0]  sq_base;
    logic [REM_W+1:0]  sq_diff;
    logic              sq_ge;
    logic [PROD_W-1:0] level;
    logic [OUT_W-1:0]  level_sat;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= RST_CHANNEL_SELECT;
            r_win  <= RST_WINDOW_LENGTH;
            r_ref  <= RST_REFERENCE_MV;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHANNEL_SELECT: r_chan <= i_cfg_wdata[0];
                CFG_WINDOW_LENGTH:  r_win  <= i_cfg_wdata[CNT_W-1:0];
                CFG_REFERENCE_MV:   r_ref  <= i_cfg_wdata[REF_W-1:0];
                default: ;
            endcase
        end
    end

    assign sel_sample = r_chan ? i_sample_second : i_sample_first;
    assign meas       = sel_sample[MEAS_W-1:0];

    // accumulate and window check
    assign sum_ext  = {1'b0, r_sum} + (SUM_W + 1)'(r_sq);
    assign sum_sat  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    assign cnt_next = {1'b0, r_taken} + 1'b1;
    assign win_ext  = (r_win == '0) ? (CNT_W + 1)'(1) : {1'b0, r_win};
    assign win_end  = !(cnt_next < win_ext);

    // restoring divide, one quotient bit per step
    assign div_trial = {r_rem, r_quo[SUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_div});
    assign div_diff  = div_trial - {1'b0, r_div};

    // square root, two radicand bits per step
    assign sq_base  = {r_srem, r_rad[RAD_W-1 -: 2]};
    assign sq_trial = (REM_W + 2)'({r_root, 2'b01});
    assign sq_ge    = (sq_base >= sq_trial);
    assign sq_diff  = sq_base - sq_trial;

    assign level     = r_prod >> SAMPLE_BITS;
    assign level_sat = (level > PROD_W'(OUT_MAX)) ? OUT_MAX : level[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_taken <= '0;
        end else if (i_cmd.acc) begin
            if (win_end) begin
                r_sum   <= '0;
                r_taken <= '0;
            end else begin
                r_sum   <= sum_sat;
                r_taken <= cnt_next[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sq <= meas * meas;
        end
        if (i_cmd.acc) begin
            r_quo <= sum_sat;
            r_div <= cnt_next[CNT_W-1:0];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], div_ge};
            r_rem <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
        end
        if (i_cmd.sqrt_load) begin
            r_rad  <= {r_quo, MEAN_SHIFT'(0)};
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad  <= r_rad << 2;
            r_srem <= sq_ge ? sq_diff[REM_W-1:0] : sq_base[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], sq_ge};
        end
        if (i_cmd.mul) begin
            r_prod <= r_root * r_ref;
        end
        if (i_cmd.out_load) begin
            r_out_data <= level_sat;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.win_end       = win_end;
    assign o_sts.out_free      = !r_out_valid || !i_out_stall;
    assign o_out_valid         = r_out_valid;
    assign o_rms_sixteenth_mv  = r_out_data;

endmodule
